@@ rtl/lsmc_pkg.sv @@
// ----------------------------------------------------------------------------
// lsmc_pkg
// Shared types and constants for the line sensor min/max calibrator.
// ----------------------------------------------------------------------------
`default_nettype none

package lsmc_pkg;

	// Command codes carried by every input item.
	typedef enum logic [2:0] {
		CMD_SAMPLE     = 3'd0,
		CMD_TICK_MS    = 3'd1,
		CMD_START      = 3'd2,
		CMD_STOP       = 3'd3,
		CMD_LOAD_ENTRY = 3'd4,
		CMD_READ_ENTRY = 3'd5,
		CMD_STATUS     = 3'd6,
		CMD_TAKE_DONE  = 3'd7
	} cmd_t;

	localparam logic [11:0] SAMPLE_TOP        = 12'd4095;
	localparam logic [15:0] ENTRY_MIN_DEFAULT = 16'd0;
	localparam logic [15:0] ENTRY_MAX_DEFAULT = 16'd4095;
	localparam logic [15:0] CAPTURE_MIN_INIT  = 16'hFFFF;
	localparam logic [15:0] CAPTURE_MAX_INIT  = 16'h0000;
	localparam logic [15:0] FALLBACK_DURATION = 16'd3000;
	localparam logic [15:0] ELAPSED_MAX       = 16'hFFFF;

	// Input item as seen on the port.
	typedef struct packed {
		logic [2:0]         cmd;
		logic [2:0]         channel;
		logic signed [15:0] raw_sample;
		logic               end_of_scan;
		logic [15:0]        start_duration_ms;
		logic               retain_extremes;
		logic [15:0]        load_min;
		logic [15:0]        load_max;
	} in_item_t;

	// Result item as seen on the port.
	typedef struct packed {
		logic [11:0] sample_out;
		logic [15:0] entry_min;
		logic [15:0] entry_max;
		logic        active;
		logic        done_flag;
		logic [15:0] duration_out;
		logic [15:0] time_left_ms;
		logic        finished_now;
	} out_item_t;

	// Classified operation handed from the front end to the back end.
	typedef struct packed {
		cmd_t        cmd;
		logic [2:0]  channel;
		logic        in_range;
		logic [11:0] smp;
		logic        end_of_scan;
		logic [15:0] start_duration_ms;
		logic        retain_extremes;
		logic [15:0] load_min;
		logic [15:0] load_max;
	} op_t;

endpackage

`default_nettype wire

@@ rtl/lsmc_front.sv @@
// ----------------------------------------------------------------------------
// lsmc_front
// Decodes the command, clamps the raw sample and checks the channel range.
// ----------------------------------------------------------------------------
`default_nettype none

module lsmc_front
	import lsmc_pkg::*;
#(
	parameter int CHANNELS = 8
) (
	input  wire in_item_t item,
	output op_t           op
);

	logic [11:0] smp;

	// Clamp the signed reading to 0..4095.
	always_comb begin
		if (item.raw_sample[15]) begin
			smp = 12'd0;
		end else if (item.raw_sample[14:12] != 3'd0) begin
			smp = SAMPLE_TOP;
		end else begin
			smp = item.raw_sample[11:0];
		end
	end

	// Build the classified operation.
	always_comb begin
		op.cmd               = cmd_t'(item.cmd);
		op.channel           = item.channel;
		op.in_range          = (32'(item.channel) < CHANNELS);
		op.smp               = smp;
		op.end_of_scan       = item.end_of_scan;
		op.start_duration_ms = item.start_duration_ms;
		op.retain_extremes   = item.retain_extremes;
		op.load_min          = item.load_min;
		op.load_max          = item.load_max;
	end

endmodule

`default_nettype wire

@@ rtl/lsmc_queue.sv @@
// ----------------------------------------------------------------------------
// lsmc_queue
// Two-entry queue of classified operations between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lsmc_queue
	import lsmc_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       push_valid,
	output logic      push_stall,
	input  wire op_t  push_data,
	output logic      pop_valid,
	input  wire       pop_stall,
	output op_t       pop_data
);

	op_t         entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	logic        pop;

	assign push_stall = (count_q == 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

@@ rtl/lsmc_back.sv @@
// ----------------------------------------------------------------------------
// lsmc_back
// Executes one operation per cycle, while the result is not stalled, on the
// calibration state and registers the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module lsmc_back
	import lsmc_pkg::*;
#(
	parameter int CHANNELS = 8
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cfg_we,
	input  wire [15:0]       cfg_wdata,
	input  wire              op_valid,
	output logic             op_stall,
	input  wire op_t         op,
	output logic             result_valid,
	input  wire              result_stall,
	output out_item_t        result
);

	logic [15:0] min_q [CHANNELS];
	logic [15:0] max_q [CHANNELS];
	logic [15:0] min_n [CHANNELS];
	logic [15:0] max_n [CHANNELS];
	logic        cal_q;
	logic        cal_n;
	logic        done_q;
	logic        done_n;
	logic [15:0] elapsed_q;
	logic [15:0] elapsed_n;
	logic [15:0] dur_q;
	logic [15:0] dur_n;
	logic        result_valid_q;
	out_item_t   result_q;
	out_item_t   result_n;
	logic        take;

	assign op_stall     = result_valid_q && result_stall;
	assign take         = op_valid && !op_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Next state and result for the operation at the head of the queue.
	always_comb begin
		logic        fix_all;
		logic        done_report;
		logic [15:0] sdur;
		logic [15:0] smp16;
		logic        hit;

		fix_all   = 1'b0;
		hit       = 1'b0;
		sdur      = op.start_duration_ms;
		smp16     = {4'd0, op.smp};
		cal_n     = cal_q;
		done_n    = done_q;
		elapsed_n = elapsed_q;
		dur_n     = dur_q;
		for (int i = 0; i < CHANNELS; i++) begin
			min_n[i] = min_q[i];
			max_n[i] = max_q[i];
		end

		case (op.cmd)
			CMD_SAMPLE: begin
				if (cal_q) begin
					for (int i = 0; i < CHANNELS; i++) begin
						hit = op.in_range && (32'(op.channel) == i);
						if (hit && smp16 < min_q[i]) begin
							min_n[i] = smp16;
						end
						if (hit && smp16 > max_q[i]) begin
							max_n[i] = smp16;
						end
					end
					if (op.end_of_scan && elapsed_q >= dur_q) begin
						fix_all = 1'b1;
						cal_n   = 1'b0;
						done_n  = 1'b1;
					end
				end
			end
			CMD_TICK_MS: begin
				if (cal_q && elapsed_q != ELAPSED_MAX) begin
					elapsed_n = elapsed_q + 16'd1;
				end
			end
			CMD_START: begin
				if (sdur == 16'd0) begin
					sdur = (dur_q != 16'd0) ? dur_q : FALLBACK_DURATION;
				end
				for (int i = 0; i < CHANNELS; i++) begin
					min_n[i] = CAPTURE_MIN_INIT;
					max_n[i] = CAPTURE_MAX_INIT;
				end
				cal_n     = 1'b1;
				done_n    = 1'b0;
				elapsed_n = 16'd0;
				dur_n     = sdur;
			end
			CMD_STOP: begin
				if (op.retain_extremes) begin
					fix_all = 1'b1;
					done_n  = 1'b1;
				end else begin
					for (int i = 0; i < CHANNELS; i++) begin
						min_n[i] = ENTRY_MIN_DEFAULT;
						max_n[i] = ENTRY_MAX_DEFAULT;
					end
				end
				cal_n = 1'b0;
			end
			CMD_LOAD_ENTRY: begin
				for (int i = 0; i < CHANNELS; i++) begin
					hit = op.in_range && (32'(op.channel) == i);
					if (hit) begin
						if (op.load_max <= op.load_min) begin
							min_n[i] = ENTRY_MIN_DEFAULT;
							max_n[i] = ENTRY_MAX_DEFAULT;
						end else begin
							min_n[i] = op.load_min;
							max_n[i] = op.load_max;
						end
					end
				end
			end
			default: begin
			end
		endcase

		// Sanitize every entry whose max does not exceed its min.
		if (fix_all) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (max_n[i] <= min_n[i]) begin
					min_n[i] = ENTRY_MIN_DEFAULT;
					max_n[i] = ENTRY_MAX_DEFAULT;
				end
			end
		end

		done_report = done_n;
		if (op.cmd == CMD_TAKE_DONE) begin
			done_n = 1'b0;
		end

		// Assemble the result from the updated state.
		result_n.sample_out = (op.cmd == CMD_SAMPLE) ? op.smp : 12'd0;
		result_n.entry_min  = 16'd0;
		result_n.entry_max  = 16'd0;
		for (int i = 0; i < CHANNELS; i++) begin
			hit = op.in_range && (32'(op.channel) == i);
			if (hit) begin
				result_n.entry_min = min_n[i];
				result_n.entry_max = max_n[i];
			end
		end
		result_n.active       = cal_n;
		result_n.done_flag    = done_report;
		result_n.duration_out = dur_n;
		result_n.time_left_ms = (cal_n && elapsed_n < dur_n) ? (dur_n - elapsed_n) : 16'd0;
		result_n.finished_now = cal_q && !cal_n;
	end

	// Calibration state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				min_q[i] <= ENTRY_MIN_DEFAULT;
				max_q[i] <= ENTRY_MAX_DEFAULT;
			end
			cal_q     <= 1'b0;
			done_q    <= 1'b0;
			elapsed_q <= 16'd0;
			dur_q     <= FALLBACK_DURATION;
		end else if (take) begin
			for (int i = 0; i < CHANNELS; i++) begin
				min_q[i] <= min_n[i];
				max_q[i] <= max_n[i];
			end
			cal_q     <= cal_n;
			done_q    <= done_n;
			elapsed_q <= elapsed_n;
			dur_q     <= dur_n;
		end else if (cfg_we) begin
			dur_q <= cfg_wdata;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (take) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= result_n;
		end
	end

endmodule

`default_nettype wire

@@ rtl/line_sensor_minmax_calibrator_top.sv @@
// Path: an item transfers into the queue, then executes from the queue head
// into the output register, where its result is valid.
// Throughput: one item per cycle while no result stalls, set by the execute
// stage of the back end; a stalled result holds it and fills the queue.
// Reset: arst_n clears the queue and the output valid flag, loads entries with
// min 0 / max 4095, stops calibration and sets the duration to 3000 ms.
// ----------------------------------------------------------------------------
// line_sensor_minmax_calibrator_top
// Per-channel min/max calibrator: front end classifies items, a two-entry
// queue decouples it from the back end that updates the calibration state.
// ----------------------------------------------------------------------------
`default_nettype none

module line_sensor_minmax_calibrator_top
	import lsmc_pkg::*;
#(
	parameter int CHANNELS = 8
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             cfg_we,
	input  wire [15:0]      cfg_wdata,
	input  wire             item_valid,
	output logic            item_stall,
	input  wire in_item_t   item,
	output logic            result_valid,
	input  wire             result_stall,
	output out_item_t       result
);

	op_t  front_op;
	op_t  queue_op;
	logic queue_valid;
	logic queue_stall;

	// Classify the incoming item.
	lsmc_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.item(item),
		.op  (front_op)
	);

	// Queue between front and back end.
	lsmc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(item_valid),
		.push_stall(item_stall),
		.push_data (front_op),
		.pop_valid (queue_valid),
		.pop_stall (queue_stall),
		.pop_data  (queue_op)
	);

	// Execute on the calibration state.
	lsmc_back #(
		.CHANNELS(CHANNELS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.op_valid    (queue_valid),
		.op_stall    (queue_stall),
		.op          (queue_op),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

`default_nettype wire
